/* src/lpr_pkg.sv */
// Shared constants, types and helpers for the lidar packet receiver.
package lpr_pkg;

    // Packet framing
    localparam int PACKET_BYTES = 22;
    localparam int POS_W        = 5;
    localparam int CHK_BYTES    = 20;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(PACKET_BYTES - 1);
    localparam logic [7:0] START_BYTE  = 8'hFA;
    localparam logic [7:0] INDEX_LOW   = 8'hA0;
    localparam logic [7:0] SECTOR_BASE = 8'd160;

    // Two packet banks: one filling, one being judged
    localparam int MEM_DEPTH = 2 * PACKET_BYTES;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    // Checksum accumulator
    localparam int ACC_W  = 27;
    localparam int FOLD_W = 15;

    // Read-out sequence: index byte, four distance words, low checksum byte
    localparam int READS  = 10;
    localparam int STEP_W = 4;

    typedef enum logic [1:0] {
        ST_ACCEPTED     = 2'd0,
        ST_BAD_INDEX    = 2'd1,
        ST_BAD_CHECKSUM = 2'd2
    } status_t;

    // Byte write into the packet store
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } wr_port_t;

    // Completed packet handed to the judge
    typedef struct packed {
        logic             start;
        logic             bank;
        logic [ACC_W-1:0] acc;
        logic [7:0]       last_byte;
    } job_t;

    // Store address of a packet position in a bank
    function automatic logic [ADDR_W-1:0] bank_addr(input logic bank,
                                                    input logic [POS_W-1:0] pos);
        logic [ADDR_W-1:0] base;
        base = bank ? ADDR_W'(PACKET_BYTES) : '0;
        return ADDR_W'(pos) + base;
    endfunction

    // Packet position fetched at each read-out step
    function automatic logic [POS_W-1:0] read_pos(input logic [STEP_W-1:0] step);
        logic [POS_W-1:0] p;
        case (step)
            4'd0:    p = 5'd1;
            4'd1:    p = 5'd4;
            4'd2:    p = 5'd5;
            4'd3:    p = 5'd8;
            4'd4:    p = 5'd9;
            4'd5:    p = 5'd12;
            4'd6:    p = 5'd13;
            4'd7:    p = 5'd16;
            4'd8:    p = 5'd17;
            4'd9:    p = 5'd20;
            default: p = 5'd1;
        endcase
        return p;
    endfunction

endpackage

/* src/lpr_judge.sv */
// Packet store, read-out sequencer and result register of the lidar receiver.
module lpr_judge
    import lpr_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  wr_port_t            wr,
    input  job_t                job,
    output logic                busy,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_status,
    output logic [6:0]          m_sector_index,
    output logic [13:0]         m_dist_a,
    output logic [13:0]         m_dist_b,
    output logic [13:0]         m_dist_c,
    output logic [13:0]         m_dist_d,
    output logic [3:0]          m_invalid_mask,
    output logic [15:0]         m_accepted_count
);

    // Packet store: two banks of 22 bytes
    logic [7:0] mem [MEM_DEPTH];

    // Sequencer and job state
    logic              busy_reg, busy_next;
    logic              issue_reg, issue_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              rd_valid_reg;
    logic [STEP_W-1:0] rd_step_reg;
    logic [7:0]        rd_data_reg;
    logic              done_reg, done_next;
    logic              bank_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [7:0]        last_reg;
    logic [7:0]        cap_reg [READS];

    // Result register
    logic              m_valid_reg, m_valid_next;
    logic [15:0]       total_reg, total_next;
    status_t           status_reg, status_c;
    logic [6:0]        sector_reg, sector_c;
    logic [13:0]       dist_reg [4];
    logic [13:0]       dist_c [4];
    logic [3:0]        mask_reg, mask_c;

    logic              load;
    logic [ADDR_W-1:0] rd_addr;

    // Store write and registered read; fill and read-out use opposite banks
    assign rd_addr = bank_addr(bank_reg, read_pos(step_reg));

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        if (issue_reg) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Sequencer next state
    always_comb begin
        busy_next  = busy_reg;
        issue_next = issue_reg;
        step_next  = step_reg;
        done_next  = done_reg;
        if (job.start) begin
            busy_next  = 1'b1;
            issue_next = 1'b1;
            step_next  = '0;
        end else if (issue_reg) begin
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(READS - 1)) begin
                issue_next = 1'b0;
            end
        end
        if (rd_valid_reg && rd_step_reg == STEP_W'(READS - 1)) begin
            done_next = 1'b1;
        end
        if (load) begin
            done_next = 1'b0;
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            issue_reg    <= 1'b0;
            step_reg     <= '0;
            rd_valid_reg <= 1'b0;
            rd_step_reg  <= '0;
            done_reg     <= 1'b0;
        end else begin
            busy_reg     <= busy_next;
            issue_reg    <= issue_next;
            step_reg     <= step_next;
            rd_valid_reg <= issue_reg;
            rd_step_reg  <= step_reg;
            done_reg     <= done_next;
        end
    end

    // Job capture and read-data collection
    always_ff @(posedge aclk) begin
        if (job.start) begin
            bank_reg <= job.bank;
            acc_reg  <= job.acc;
            last_reg <= job.last_byte;
        end
        if (rd_valid_reg) begin
            cap_reg[rd_step_reg] <= rd_data_reg;
        end
    end

    // Packet judgment from the collected bytes
    always_comb begin
        logic [FOLD_W-1:0] folded;
        logic [15:0]       received;
        logic              idx_ok;
        logic [15:0]       w;
        folded   = FOLD_W'(acc_reg[FOLD_W-1:0] + FOLD_W'(acc_reg[ACC_W-1:FOLD_W]));
        received = {last_reg, cap_reg[READS-1]};
        idx_ok   = (cap_reg[0] >= INDEX_LOW) && (cap_reg[0] < START_BYTE);
        if (!idx_ok) begin
            status_c = ST_BAD_INDEX;
        end else if ({1'b0, folded} != received) begin
            status_c = ST_BAD_CHECKSUM;
        end else begin
            status_c = ST_ACCEPTED;
        end
        sector_c = (status_c == ST_BAD_INDEX) ? '0 : 7'(cap_reg[0] - SECTOR_BASE);
        mask_c   = '0;
        for (int n = 0; n < 4; n++) begin
            w = {cap_reg[2 + 2 * n], cap_reg[1 + 2 * n]};
            dist_c[n] = '0;
            if (status_c == ST_ACCEPTED) begin
                if (w[15]) begin
                    mask_c[n] = 1'b1;
                end else begin
                    dist_c[n] = w[13:0];
                end
            end
        end
    end

    // Output register
    assign load = done_reg && (!m_valid_reg || m_ready);

    always_comb begin
        m_valid_next = m_valid_reg;
        total_next   = total_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (load) begin
            m_valid_next = 1'b1;
            if (status_c == ST_ACCEPTED) begin
                total_next = total_reg + 16'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            total_reg   <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            total_reg   <= total_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            status_reg <= status_c;
            sector_reg <= sector_c;
            dist_reg   <= dist_c;
            mask_reg   <= mask_c;
        end
    end

    assign busy             = busy_reg;
    assign m_valid          = m_valid_reg;
    assign m_status         = status_reg;
    assign m_sector_index   = sector_reg;
    assign m_dist_a         = dist_reg[0];
    assign m_dist_b         = dist_reg[1];
    assign m_dist_c         = dist_reg[2];
    assign m_dist_d         = dist_reg[3];
    assign m_invalid_mask   = mask_reg;
    assign m_accepted_count = total_reg;

endmodule

/* src/lidar_packet_receiver.sv */
// Top level of the lidar packet receiver: byte framing and running checksum.
//
//   channel  direction  handshake          payload
//   s_       in         s_valid / s_ready  s_rx_byte (8)
//   m_       out        m_valid / m_ready  m_status, m_sector_index, m_dist_a..d,
//                                          m_invalid_mask, m_accepted_count
//
// One byte is taken per cycle while s_ready is high. Each byte is written into
// one bank of a two-bank packet store; the checksum is accumulated as the bytes
// pass. After the last byte that bank is read out, one byte a cycle over ten
// reads, while the other bank fills; then the result register loads when free.
// The last byte of a packet waits only while the previous packet's read-out
// or its result is still pending. aresetn (synchronous) returns to hunting.
module lidar_packet_receiver
    import lpr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [6:0]  m_sector_index,
    output logic [13:0] m_dist_a,
    output logic [13:0] m_dist_b,
    output logic [13:0] m_dist_c,
    output logic [13:0] m_dist_d,
    output logic [3:0]  m_invalid_mask,
    output logic [15:0] m_accepted_count
);

    logic             in_packet_reg, in_packet_next;
    logic [POS_W-1:0] count_reg, count_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [7:0]       low_hold_reg, low_hold_next;
    logic             bank_reg, bank_next;

    logic             busy;
    logic             take;
    logic [POS_W-1:0] pos;
    logic [ACC_W-1:0] acc_base;
    wr_port_t         wr;
    job_t             job;

    // Hold only the closing byte while the judge is still occupied
    assign s_ready = !(in_packet_reg && count_reg == LAST_POS && busy);
    assign take    = s_valid && s_ready && (in_packet_reg || s_rx_byte == START_BYTE);
    assign pos      = in_packet_reg ? count_reg : '0;
    assign acc_base = in_packet_reg ? acc_reg : '0;

    // Framing and checksum next state
    always_comb begin
        in_packet_next = in_packet_reg;
        count_next     = count_reg;
        acc_next       = acc_reg;
        low_hold_next  = low_hold_reg;
        bank_next      = bank_reg;
        wr.en          = take;
        wr.addr        = bank_addr(bank_reg, pos);
        wr.data        = s_rx_byte;
        job.start      = 1'b0;
        job.bank       = bank_reg;
        job.acc        = acc_reg;
        job.last_byte  = s_rx_byte;
        if (take) begin
            acc_next = acc_base;
            if (pos < POS_W'(CHK_BYTES)) begin
                if (!pos[0]) begin
                    low_hold_next = s_rx_byte;
                end else begin
                    acc_next = ACC_W'({acc_base, 1'b0} + ACC_W'({s_rx_byte, low_hold_reg}));
                end
            end
            if (pos == LAST_POS) begin
                in_packet_next = 1'b0;
                count_next     = '0;
                job.start      = 1'b1;
                bank_next      = !bank_reg;
            end else begin
                in_packet_next = 1'b1;
                count_next     = pos + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_packet_reg <= 1'b0;
            count_reg     <= '0;
            acc_reg       <= '0;
            low_hold_reg  <= '0;
            bank_reg      <= 1'b0;
        end else begin
            in_packet_reg <= in_packet_next;
            count_reg     <= count_next;
            acc_reg       <= acc_next;
            low_hold_reg  <= low_hold_next;
            bank_reg      <= bank_next;
        end
    end

    lpr_judge u_judge (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .wr               (wr),
        .job              (job),
        .busy             (busy),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_sector_index   (m_sector_index),
        .m_dist_a         (m_dist_a),
        .m_dist_b         (m_dist_b),
        .m_dist_c         (m_dist_c),
        .m_dist_d         (m_dist_d),
        .m_invalid_mask   (m_invalid_mask),
        .m_accepted_count (m_accepted_count)
    );

endmodule

/* verif/tb_lidar_packet_receiver.sv */
// Self-checking testbench for the lidar packet receiver: framing, checksum and result decoding.
module tb_lidar_packet_receiver;
    import lpr_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_BYTES = 1100;
    localparam int MAX_PRINTED = 20;

    typedef struct packed {
        status_t     status;
        logic [6:0]  sector;
        logic [13:0] dist_a;
        logic [13:0] dist_b;
        logic [13:0] dist_c;
        logic [13:0] dist_d;
        logic [3:0]  mask;
        logic [15:0] count;
    } scan_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_rx_byte;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_status;
    logic [6:0]  m_sector_index;
    logic [13:0] m_dist_a;
    logic [13:0] m_dist_b;
    logic [13:0] m_dist_c;
    logic [13:0] m_dist_d;
    logic [3:0]  m_invalid_mask;
    logic [15:0] m_accepted_count;

    // Decoder shadow state
    logic        in_frame;
    logic [4:0]  frame_pos;
    logic [26:0] sum_acc;
    logic [7:0]  low_hold;
    logic [7:0]  frame_store [PACKET_BYTES];
    logic [15:0] good_total;
    scan_result_t pending_scans[$];

    // Packet under construction for transmit
    logic [7:0] tx_frame [PACKET_BYTES];

    // Run bookkeeping
    int cycle_count;
    int error_count;
    int framed_bytes;
    int scans_checked;
    int n_good;
    int n_bad_index;
    int n_bad_sum;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_request;
    int hold_left;

    lidar_packet_receiver i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_sector_index   (m_sector_index),
        .m_dist_a         (m_dist_a),
        .m_dist_b         (m_dist_b),
        .m_dist_c         (m_dist_c),
        .m_dist_d         (m_dist_d),
        .m_invalid_mask   (m_invalid_mask),
        .m_accepted_count (m_accepted_count)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Cycle counter and watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d scans outstanding",
                     cycle_count, pending_scans.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Folded 15-bit checksum of the running accumulator
    function automatic logic [14:0] fold_sum(input logic [26:0] acc);
        return acc[14:0] + 15'(acc[26:15]);
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("mismatch at cycle %0d: %s got 0x%0h, wanted 0x%0h",
                     cycle_count, what, got, want);
    endtask

    // Shadow decoder: one accepted byte in, a predicted scan out on the last byte
    function automatic void decode_byte(input logic [7:0] b);
        logic [4:0]  p;
        logic [7:0]  idx;
        logic [15:0] rcv;
        logic [15:0] w;
        logic [13:0] d [4];
        logic [3:0]  mask;
        status_t     st;
        scan_result_t r;

        if (!in_frame) begin
            if (b != START_BYTE)
                return;
            in_frame = 1'b1;
            frame_pos = '0;
            sum_acc = '0;
        end
        framed_bytes++;
        p = frame_pos;
        frame_store[p] = b;

        // Words of bytes 0..19 feed the checksum
        if (p < 5'(CHK_BYTES)) begin
            if (!p[0])
                low_hold = b;
            else
                sum_acc = (sum_acc << 1) + 27'({b, low_hold});
        end

        if (p < LAST_POS) begin
            frame_pos = p + 5'd1;
            return;
        end

        // Last byte: judge and go back to hunting
        in_frame = 1'b0;
        frame_pos = '0;
        idx = frame_store[1];
        rcv = {frame_store[21], frame_store[20]};
        if (!(idx >= INDEX_LOW && idx < START_BYTE))
            st = ST_BAD_INDEX;
        else if ({1'b0, fold_sum(sum_acc)} != rcv)
            st = ST_BAD_CHECKSUM;
        else
            st = ST_ACCEPTED;

        mask = '0;
        for (int n = 0; n < 4; n++) begin
            w = {frame_store[5 + 4 * n], frame_store[4 + 4 * n]};
            if (st != ST_ACCEPTED) begin
                d[n] = '0;
            end else if (w[15]) begin
                d[n] = '0;
                mask[n] = 1'b1;
            end else begin
                d[n] = w[13:0];
            end
        end

        case (st)
            ST_ACCEPTED: begin
                good_total = good_total + 16'd1;
                n_good++;
            end
            ST_BAD_INDEX: n_bad_index++;
            default:      n_bad_sum++;
        endcase

        r.status = st;
        r.sector = (st == ST_BAD_INDEX) ? 7'd0 : 7'(idx - SECTOR_BASE);
        r.dist_a = d[0];
        r.dist_b = d[1];
        r.dist_c = d[2];
        r.dist_d = d[3];
        r.mask   = mask;
        r.count  = good_total;
        pending_scans.push_back(r);
    endfunction

    // Result checker
    always @(posedge aclk) begin
        scan_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_scans.size() == 0) begin
                report_mismatch("unexpected scan, status", m_status, 0);
            end else begin
                want = pending_scans.pop_front();
                scans_checked++;
                if (m_status != want.status)
                    report_mismatch("status", m_status, want.status);
                if (m_sector_index != want.sector)
                    report_mismatch("sector_index", m_sector_index, want.sector);
                if (m_dist_a != want.dist_a)
                    report_mismatch("dist_a", m_dist_a, want.dist_a);
                if (m_dist_b != want.dist_b)
                    report_mismatch("dist_b", m_dist_b, want.dist_b);
                if (m_dist_c != want.dist_c)
                    report_mismatch("dist_c", m_dist_c, want.dist_c);
                if (m_dist_d != want.dist_d)
                    report_mismatch("dist_d", m_dist_d, want.dist_d);
                if (m_invalid_mask != want.mask)
                    report_mismatch("invalid_mask", m_invalid_mask, want.mask);
                if (m_accepted_count != want.count)
                    report_mismatch("accepted_count", m_accepted_count, want.count);
            end
        end
    end

    // Result-side ready: random stalls plus an occasional long hold-off
    always @(negedge aclk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // One byte transaction, with an optional idle gap in front
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
        @(negedge aclk);
        repeat (gap) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!(s_valid && s_ready));
        decode_byte(b);
    endtask

    // Stop sending and let every outstanding scan come out
    task automatic drain_scans();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_scans.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Random well-formed frame with an in-range index
    task automatic fill_frame();
        tx_frame[0] = START_BYTE;
        tx_frame[1] = 8'($urandom_range(INDEX_LOW, START_BYTE - 1));
        for (int i = 2; i < PACKET_BYTES; i++)
            tx_frame[i] = 8'($urandom);
        // invalid flag on about a quarter of the distances
        for (int n = 0; n < 4; n++)
            tx_frame[5 + 4 * n][7] = ($urandom_range(3) == 0);
    endtask

    task automatic set_dist(input int n, input logic [15:0] w);
        tx_frame[4 + 4 * n] = w[7:0];
        tx_frame[5 + 4 * n] = w[15:8];
    endtask

    // Write the correct checksum into bytes 20..21
    task automatic seal_frame();
        logic [26:0] acc;
        logic [14:0] f;
        acc = '0;
        for (int i = 0; i < CHK_BYTES; i += 2)
            acc = (acc << 1) + 27'({tx_frame[i + 1], tx_frame[i]});
        f = fold_sum(acc);
        tx_frame[20] = f[7:0];
        tx_frame[21] = {1'b0, f[14:8]};
    endtask

    task automatic send_frame();
        for (int i = 0; i < PACKET_BYTES; i++)
            send_byte(tx_frame[i]);
    endtask

    task automatic send_noise(input int n);
        logic [7:0] b;
        repeat (n) begin
            b = 8'($urandom);
            if (b == START_BYTE)
                b = 8'h00;
            send_byte(b);
        end
    endtask

    // Bytes outside a packet are dropped
    task automatic test_hunting();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(START_BYTE - 8'd1);
        send_byte(START_BYTE + 8'd1);
    endtask

    // Index range ends, distance extremes, invalid flags, start byte as data
    task automatic test_distances();
        fill_frame();
        tx_frame[1] = INDEX_LOW;
        set_dist(0, 16'h0000);
        set_dist(1, 16'h3FFF);
        set_dist(2, 16'h7FFF);
        set_dist(3, 16'h8000);
        seal_frame();
        send_frame();

        fill_frame();
        tx_frame[1] = START_BYTE - 8'd1;
        for (int i = 2; i < CHK_BYTES; i++)
            tx_frame[i] = START_BYTE;
        set_dist(0, 16'hFFFF);
        set_dist(3, 16'hBFFF);
        seal_frame();
        send_frame();
    endtask

    // Index just below range, start byte as index (also a checksum error)
    task automatic test_bad_index();
        fill_frame();
        tx_frame[1] = INDEX_LOW - 8'd1;
        seal_frame();
        send_frame();

        fill_frame();
        tx_frame[1] = START_BYTE;
        seal_frame();
        tx_frame[20] = ~tx_frame[20];
        send_frame();
    endtask

    // Plain checksum error and the unreachable high checksum bit
    task automatic test_checksum();
        fill_frame();
        seal_frame();
        tx_frame[20][0] = ~tx_frame[20][0];
        send_frame();

        fill_frame();
        seal_frame();
        tx_frame[21][7] = 1'b1;
        send_frame();
    endtask

    // Long result hold-off while frames keep coming, so the input stalls
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 300;
        repeat (4) begin
            fill_frame();
            seal_frame();
            send_frame();
        end
        drain_scans();
    endtask

    // Mostly valid frames with random content, some broken traffic
    task automatic test_random_traffic(input int send_pct, input int stall_pct, input int nbytes);
        int stop_at;
        int pick;
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        stop_at = framed_bytes + nbytes;
        while (framed_bytes < stop_at) begin
            if ($urandom_range(99) < 30)
                send_noise($urandom_range(1, 3));
            pick = $urandom_range(99);
            fill_frame();
            if (pick < 65) begin
                seal_frame();
            end else if (pick < 75) begin
                seal_frame();
                tx_frame[1] = ($urandom_range(1) == 0) ?
                              8'($urandom_range(0, INDEX_LOW - 1)) :
                              8'($urandom_range(START_BYTE, 255));
            end else if (pick < 87) begin
                seal_frame();
                tx_frame[20 + $urandom_range(1)][$urandom_range(7)] ^= 1'b1;
            end else if (pick < 93) begin
                for (int i = 0; i < 4; i++)
                    tx_frame[$urandom_range(2, CHK_BYTES - 1)] = START_BYTE;
                seal_frame();
            end else begin
                // raw bytes, then fill out whatever packet they left open
                for (int i = 0; i < PACKET_BYTES; i++)
                    tx_frame[i] = 8'($urandom);
                tx_frame[$urandom_range(0, 3)] = START_BYTE;
            end
            send_frame();
            while (in_frame)
                send_byte(8'($urandom));
        end
        drain_scans();
    endtask

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_rx_byte      = '0;
        m_ready        = 1'b0;
        cycle_count    = 0;
        error_count    = 0;
        framed_bytes   = 0;
        scans_checked  = 0;
        n_good         = 0;
        n_bad_index    = 0;
        n_bad_sum      = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 0;
        hold_left      = 0;
        in_frame       = 1'b0;
        frame_pos      = '0;
        sum_acc        = '0;
        low_hold       = '0;
        good_total     = '0;
        for (int i = 0; i < PACKET_BYTES; i++)
            frame_store[i] = '0;

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_hunting();
        test_distances();
        test_bad_index();
        test_checksum();
        drain_scans();
        test_backpressure();

        test_random_traffic(0, 0, RANDOM_BYTES / 4);
        test_random_traffic(47, 0, RANDOM_BYTES / 4);
        test_random_traffic(0, 47, RANDOM_BYTES / 4);
        test_random_traffic(21, 21, RANDOM_BYTES / 4);

        $display("covered %0d packet bytes, %0d scans checked in %0d cycles",
                 framed_bytes, scans_checked, cycle_count);
        $display("scans: %0d accepted, %0d bad index, %0d bad checksum; %0d mismatches",
                 n_good, n_bad_index, n_bad_sum, error_count);
        if (error_count == 0 && pending_scans.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
